// ===== hdl/highest_note_priority_tracker_defines.svh =====
// Assertion macros used by the checker file.
`ifndef HIGHEST_NOTE_PRIORITY_TRACKER_DEFINES_SVH
`define HIGHEST_NOTE_PRIORITY_TRACKER_DEFINES_SVH

// Next-cycle implication, masked while reset is asserted.
`define HNPT_AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("hnpt: check failed");

// Next-cycle implication that also holds across reset.
`define HNPT_AST_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("hnpt: reset check failed");

`endif

// ===== hdl/hnpt_pkg.sv =====
package hnpt_pkg;

    // field widths
    localparam int unsigned ACT_W  = 2;
    localparam int unsigned TRK_W  = 4;
    localparam int unsigned NOTE_W = 7;

    // word widths on the stream ports
    localparam int unsigned IN_W  = 16;
    localparam int unsigned OUT_W = 8;

    // store geometry
    localparam int unsigned TRACKS   = 16;
    localparam int unsigned NOTES    = 128;
    localparam int unsigned ROW_BITS = 64;
    localparam int unsigned ROWS     = TRACKS * 2;
    localparam int unsigned ROW_AW   = $clog2(ROWS);
    localparam int unsigned BIT_W    = $clog2(ROW_BITS);
    localparam int unsigned CNT_W    = $clog2(TRACKS + 1);
    localparam int unsigned HELD_W   = $clog2(TRACKS * (NOTES - 1) + 1);

    // voice search tree: groups of eight notes, groups bundled in fours
    localparam int unsigned GRP_SIZE = 8;
    localparam int unsigned GRP_W    = $clog2(GRP_SIZE);
    localparam int unsigned NGRP     = NOTES / GRP_SIZE;
    localparam int unsigned GSEL_W   = $clog2(NGRP);
    localparam int unsigned QUAD     = 4;
    localparam int unsigned NQUAD    = NGRP / QUAD;

    // action codes
    localparam logic [ACT_W-1:0] ACT_ON      = 2'd0;
    localparam logic [ACT_W-1:0] ACT_OFF     = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR   = 2'd3;

endpackage

// ===== hdl/hnpt_ram.sv =====
// Simple dual-port RAM, one write and one registered read per cycle.
module hnpt_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 32,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/hnpt_pick.sv =====
// Highest live note: registered per-group search, then a short group select.
module hnpt_pick
    import hnpt_pkg::*;
(
    input  logic              aclk,
    input  logic [NOTES-1:0]  live_i,
    output logic [NOTE_W-1:0] note_o
);

    logic             grp_any_next [NGRP];
    logic [GRP_W-1:0] grp_idx_next [NGRP];
    logic             grp_any_reg  [NGRP];
    logic [GRP_W-1:0] grp_idx_reg  [NGRP];

    logic              quad_any [NQUAD];
    logic [GSEL_W-1:0] quad_grp [NQUAD];
    logic [GSEL_W-1:0] top_grp;
    logic              top_any;

    // per-group highest set bit
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            grp_any_next[g] = 1'b0;
            grp_idx_next[g] = '0;
            for (int b = 0; b < GRP_SIZE; b++) begin
                if (live_i[g * GRP_SIZE + b]) begin
                    grp_any_next[g] = 1'b1;
                    grp_idx_next[g] = GRP_W'(b);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int g = 0; g < NGRP; g++) begin
            grp_any_reg[g] <= grp_any_next[g];
            grp_idx_reg[g] <= grp_idx_next[g];
        end
    end

    // highest non-empty group, four groups at a time
    always_comb begin
        for (int q = 0; q < NQUAD; q++) begin
            quad_any[q] = 1'b0;
            quad_grp[q] = '0;
            for (int k = 0; k < QUAD; k++) begin
                if (grp_any_reg[q * QUAD + k]) begin
                    quad_any[q] = 1'b1;
                    quad_grp[q] = GSEL_W'(q * QUAD + k);
                end
            end
        end
        top_any = 1'b0;
        top_grp = '0;
        for (int q = 0; q < NQUAD; q++) begin
            if (quad_any[q]) begin
                top_any = 1'b1;
                top_grp = quad_grp[q];
            end
        end
    end

    // rest when nothing is held
    assign note_o = top_any ? {top_grp, grp_idx_reg[top_grp]} : '0;

endmodule

// ===== hdl/highest_note_priority_tracker.sv =====
// Path from accept to result valid: note on/off runs ST_MOD, ST_VOICE, ST_DONE; a rest-note event
//   or clear runs ST_VOICE, ST_DONE; a release runs ST_RLREAD, a one-note-per-cycle count RMW sweep
//   and ST_DRAIN per row, lower then upper, then ST_VOICE, ST_DONE. One word at a time: the next word
//   is taken once the result is loaded, which waits while m_tready stalls the previous result.
// Reset: aresetn (synchronous, active low) clears valid bits of the hold rows, the live-note
//   map and the held total at once; no clearing pass, the block is ready right after reset.
module highest_note_priority_tracker
    import hnpt_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // action[1:0], track[5:2], note[12:6], zero pad
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // voiced_note[6:0], changed_hold[7]
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MOD    = 3'd1;
    localparam logic [2:0] ST_RLREAD = 3'd2;
    localparam logic [2:0] ST_SWEEP  = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;
    localparam logic [2:0] ST_VOICE  = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    function automatic logic [ROW_AW-1:0] row_addr(input logic [TRK_W-1:0] trk,
                                                   input logic half);
        row_addr = ROW_AW'({trk, half});
    endfunction

    // input word fields
    logic [ACT_W-1:0]  s_action;
    logic [TRK_W-1:0]  s_track;
    logic [NOTE_W-1:0] s_note;
    logic              s_acc;
    logic              trk_ok;

    assign s_action = s_tdata[ACT_W-1:0];
    assign s_track  = s_tdata[ACT_W +: TRK_W];
    assign s_note   = s_tdata[ACT_W + TRK_W +: NOTE_W];
    assign s_acc    = s_tvalid && s_tready;
    assign trk_ok   = 32'(s_track) < TRACKS;

    // control and payload registers
    logic [2:0]        state_reg, state_next;
    logic [ACT_W-1:0]  act_reg, act_next;
    logic [TRK_W-1:0]  trk_reg, trk_next;
    logic [NOTE_W-1:0] note_reg, note_next;
    logic              chg_reg, chg_next;
    logic              half_reg, half_next;
    logic [BIT_W-1:0]  sw_idx_reg, sw_idx_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    logic              pend_reg, pend_next;
    logic [NOTE_W-1:0] pend_addr_reg, pend_addr_next;
    logic [NOTES-1:0]  live_reg, live_next;
    logic [ROWS-1:0]   row_vld_reg, row_vld_next;
    logic [HELD_W-1:0] total_reg, total_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [NOTE_W-1:0] m_note_reg, m_note_next;
    logic              m_chg_reg, m_chg_next;

    // memory ports
    logic                hold_wr_en, hold_rd_en;
    logic [ROW_AW-1:0]   hold_wr_addr, hold_rd_addr;
    logic [ROW_BITS-1:0] hold_wr_data, hold_rd_data;
    logic                cnt_wr_en, cnt_rd_en;
    logic [NOTE_W-1:0]   cnt_wr_addr, cnt_rd_addr;
    logic [CNT_W-1:0]    cnt_wr_data, cnt_rd_data;

    // working values
    logic [ROW_AW-1:0]   cur_row;
    logic [ROW_BITS-1:0] row_word;
    logic [ROW_BITS-1:0] note_mask;
    logic                note_bit;
    logic [CNT_W-1:0]    cnt_cur;
    logic [CNT_W-1:0]    pend_cnt;
    logic [NOTE_W-1:0]   pick_note;

    hnpt_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS)) u_hold_ram (
        .aclk    (aclk),
        .wr_en   (hold_wr_en),
        .wr_addr (hold_wr_addr),
        .wr_data (hold_wr_data),
        .rd_en   (hold_rd_en),
        .rd_addr (hold_rd_addr),
        .rd_data (hold_rd_data)
    );

    hnpt_ram #(.WIDTH(CNT_W), .DEPTH(NOTES)) u_cnt_ram (
        .aclk    (aclk),
        .wr_en   (cnt_wr_en),
        .wr_addr (cnt_wr_addr),
        .wr_data (cnt_wr_data),
        .rd_en   (cnt_rd_en),
        .rd_addr (cnt_rd_addr),
        .rd_data (cnt_rd_data)
    );

    hnpt_pick u_pick (
        .aclk   (aclk),
        .live_i (live_reg),
        .note_o (pick_note)
    );

    // row under work; a row never written reads as zero
    assign cur_row   = (state_reg == ST_MOD) ? row_addr(trk_reg, note_reg[NOTE_W-1])
                                             : row_addr(trk_reg, half_reg);
    assign row_word  = row_vld_reg[cur_row] ? hold_rd_data : '0;
    assign note_mask = {{(ROW_BITS-1){1'b0}}, 1'b1} << note_reg[BIT_W-1:0];
    assign note_bit  = row_word[note_reg[BIT_W-1:0]];
    // a note that is not live has a zero count, whatever the RAM holds
    assign cnt_cur   = live_reg[note_reg] ? cnt_rd_data : '0;
    assign pend_cnt  = live_reg[pend_addr_reg] ? cnt_rd_data : '0;

    always_comb begin
        state_next     = state_reg;
        act_next       = act_reg;
        trk_next       = trk_reg;
        note_next      = note_reg;
        chg_next       = chg_reg;
        half_next      = half_reg;
        sw_idx_next    = sw_idx_reg;
        row_next       = row_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        live_next      = live_reg;
        row_vld_next   = row_vld_reg;
        total_next     = total_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_note_next    = m_note_reg;
        m_chg_next     = m_chg_reg;

        hold_wr_en   = 1'b0;
        hold_wr_addr = cur_row;
        hold_wr_data = '0;
        hold_rd_en   = 1'b0;
        hold_rd_addr = row_addr(s_track, s_note[NOTE_W-1]);
        cnt_wr_en    = 1'b0;
        cnt_wr_addr  = note_reg;
        cnt_wr_data  = '0;
        cnt_rd_en    = 1'b0;
        cnt_rd_addr  = s_note;

        // output word taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // release sweep: write back the count read in the previous cycle
        if (pend_reg) begin
            cnt_wr_en               = 1'b1;
            cnt_wr_addr             = pend_addr_reg;
            cnt_wr_data             = pend_cnt - CNT_W'(1);
            live_next[pend_addr_reg] = (pend_cnt != CNT_W'(1));
            total_next              = total_reg - HELD_W'(1);
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    act_next  = s_action;
                    trk_next  = s_track;
                    note_next = s_note;
                    chg_next  = 1'b0;
                    half_next = 1'b0;
                    state_next = ST_VOICE;
                    case (s_action)
                        ACT_CLEAR: begin
                            chg_next     = (total_reg != '0);
                            row_vld_next = '0;
                            live_next    = '0;
                            total_next   = '0;
                        end
                        ACT_RELEASE: begin
                            if (trk_ok) begin
                                hold_rd_en   = 1'b1;
                                hold_rd_addr = row_addr(s_track, 1'b0);
                                state_next   = ST_RLREAD;
                            end
                        end
                        default: begin
                            if (trk_ok && (s_note != '0)) begin
                                hold_rd_en = 1'b1;
                                cnt_rd_en  = 1'b1;
                                state_next = ST_MOD;
                            end
                        end
                    endcase
                end
            end

            // note on / note off read-modify-write
            ST_MOD: begin
                if ((act_reg == ACT_ON) && !note_bit) begin
                    hold_wr_en              = 1'b1;
                    hold_wr_data            = row_word | note_mask;
                    row_vld_next[cur_row]   = 1'b1;
                    cnt_wr_en               = 1'b1;
                    cnt_wr_data             = cnt_cur + CNT_W'(1);
                    live_next[note_reg]     = 1'b1;
                    total_next              = total_reg + HELD_W'(1);
                    chg_next                = 1'b1;
                end else if ((act_reg == ACT_OFF) && note_bit) begin
                    hold_wr_en              = 1'b1;
                    hold_wr_data            = row_word & ~note_mask;
                    row_vld_next[cur_row]   = 1'b1;
                    cnt_wr_en               = 1'b1;
                    cnt_wr_data             = cnt_cur - CNT_W'(1);
                    live_next[note_reg]     = (cnt_cur != CNT_W'(1));
                    total_next              = total_reg - HELD_W'(1);
                    chg_next                = 1'b1;
                end
                state_next = ST_VOICE;
            end

            // release: take the row, clear it in the RAM
            ST_RLREAD: begin
                row_next              = row_word;
                hold_wr_en            = 1'b1;
                hold_wr_data          = '0;
                row_vld_next[cur_row] = 1'b1;
                if (row_word != '0) begin
                    chg_next = 1'b1;
                end
                sw_idx_next = '0;
                state_next  = ST_SWEEP;
            end

            // release: one note per cycle, read its count for the next cycle
            ST_SWEEP: begin
                row_next    = row_reg >> 1;
                sw_idx_next = sw_idx_reg + BIT_W'(1);
                if (row_reg[0]) begin
                    cnt_rd_en      = 1'b1;
                    cnt_rd_addr    = {half_reg, sw_idx_reg};
                    pend_next      = 1'b1;
                    pend_addr_next = {half_reg, sw_idx_reg};
                end
                if (&sw_idx_reg) begin
                    state_next = ST_DRAIN;
                end
            end

            // last count write lands here; go on to the upper row after the lower one, else to ST_VOICE
            ST_DRAIN: begin
                if (!half_reg) begin
                    half_next    = 1'b1;
                    hold_rd_en   = 1'b1;
                    hold_rd_addr = row_addr(trk_reg, 1'b1);
                    state_next   = ST_RLREAD;
                end else begin
                    state_next = ST_VOICE;
                end
            end

            // search tree registers the updated live map
            ST_VOICE: begin
                state_next = ST_DONE;
            end

            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_note_next   = pick_note;
                    m_chg_next    = chg_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pend_reg     <= 1'b0;
            live_reg     <= '0;
            row_vld_reg  <= '0;
            total_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            live_reg     <= live_next;
            row_vld_reg  <= row_vld_next;
            total_reg    <= total_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        act_reg       <= act_next;
        trk_reg       <= trk_next;
        note_reg      <= note_next;
        chg_reg       <= chg_next;
        half_reg      <= half_next;
        sw_idx_reg    <= sw_idx_next;
        row_reg       <= row_next;
        pend_addr_reg <= pend_addr_next;
        m_note_reg    <= m_note_next;
        m_chg_reg     <= m_chg_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_chg_reg, m_note_reg};

endmodule

// ===== hdl/hnpt_checker.sv =====
`include "highest_note_priority_tracker_defines.svh"

// Port-level checks for the tracker.
module hnpt_checker
    import hnpt_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // a stalled result word stays put
    `HNPT_AST_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // one word at a time: busy right after taking a word
    `HNPT_AST_NEXT(a_in_busy, s_tvalid && s_tready, !s_tready)

    // reset leaves the block idle with no result pending
    `HNPT_AST_RST(a_rst_idle, !aresetn, !m_tvalid && s_tready)

endmodule

bind highest_note_priority_tracker hnpt_checker u_hnpt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/testbench.sv =====
module testbench;
    import hnpt_pkg::*;

    localparam int unsigned RANDOM_EVENTS = 1200;
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned DRAIN_CYCLES  = 300;
    localparam int unsigned HOLDOFF_AT    = 400;
    localparam int unsigned HOLDOFF_LEN   = 400;

    typedef struct packed {
        logic [NOTE_W-1:0] note;
        logic [TRK_W-1:0]  trk;
        logic [ACT_W-1:0]  act;
    } note_event_t;

    typedef struct packed {
        logic              changed;
        logic [NOTE_W-1:0] voice;
    } voice_result_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;   // action[1:0], track[5:2], note[12:6], zero pad
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;         // voiced_note[6:0], changed_hold[7]

    highest_note_priority_tracker dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    note_event_t   pending_events[$];
    voice_result_t expected_voices[$];
    int unsigned   err_count      = 0;
    int unsigned   accepted_count = 0;
    int unsigned   cycle_count    = 0;
    logic          in_taken       = 1'b0;

    // predictor state: hold bits per track, holder count per note
    logic [NOTES-1:0] track_notes [TRACKS];
    logic [CNT_W-1:0] holders [NOTES];

    // shadow of held notes used only to steer the generator
    logic [NOTES-1:0] gen_hold [TRACKS];

    task automatic flag_error(input string msg);
        if (err_count < 10)
            $display("mismatch: %s", msg);
        err_count++;
    endtask

    function automatic voice_result_t predict_voice(input note_event_t e);
        voice_result_t r;
        int n;
        r.changed = 1'b0;
        r.voice   = '0;
        case (e.act)
            ACT_ON: begin
                if (e.note != 0 && !track_notes[e.trk][e.note]) begin
                    track_notes[e.trk][e.note] = 1'b1;
                    holders[e.note]++;
                    r.changed = 1'b1;
                end
            end
            ACT_OFF: begin
                if (e.note != 0 && track_notes[e.trk][e.note]) begin
                    track_notes[e.trk][e.note] = 1'b0;
                    holders[e.note]--;
                    r.changed = 1'b1;
                end
            end
            ACT_RELEASE: begin
                for (n = 1; n < NOTES; n++) begin
                    if (track_notes[e.trk][n]) begin
                        track_notes[e.trk][n] = 1'b0;
                        holders[n]--;
                        r.changed = 1'b1;
                    end
                end
            end
            default: begin
                for (n = 0; n < TRACKS; n++) begin
                    if (track_notes[n] != '0)
                        r.changed = 1'b1;
                    track_notes[n] = '0;
                end
                for (n = 0; n < NOTES; n++)
                    holders[n] = '0;
            end
        endcase
        // highest note with any holder, rest otherwise
        for (n = NOTES - 1; n >= 1; n--) begin
            if (holders[n] != 0) begin
                r.voice = NOTE_W'(n);
                break;
            end
        end
        return r;
    endfunction

    task automatic add_event(input logic [ACT_W-1:0] act, input int trk, input int note);
        note_event_t e;
        int t;
        e.act  = act;
        e.trk  = TRK_W'(trk);
        e.note = NOTE_W'(note);
        pending_events.push_back(e);
        case (act)
            ACT_ON:      if (e.note != 0) gen_hold[e.trk][e.note] = 1'b1;
            ACT_OFF:     gen_hold[e.trk][e.note] = 1'b0;
            ACT_RELEASE: gen_hold[e.trk] = '0;
            default:     for (t = 0; t < TRACKS; t++) gen_hold[t] = '0;
        endcase
    endtask

    // mostly a narrow cluster so several tracks share notes
    function automatic int pick_note();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(60, 63);
        if (r < 60) begin
            case ($urandom_range(0, 3))
                0: return 127;
                1: return 1;
                2: return 64;
                default: return 63;
            endcase
        end
        return $urandom_range(0, NOTES - 1);
    endfunction

    // a note the track holds, scanning from a random start; 0 if none
    function automatic int pick_held(input int trk);
        int start;
        int k;
        int n;
        start = $urandom_range(1, NOTES - 1);
        for (k = 0; k < NOTES - 1; k++) begin
            n = 1 + (start - 1 + k) % (NOTES - 1);
            if (gen_hold[trk][n])
                return n;
        end
        return 0;
    endfunction

    // stimulus, then wait for drain and report
    initial begin
        int i;
        int t;
        int r;
        int trk;
        int note;
        for (i = 0; i < TRACKS; i++) begin
            track_notes[i] = '0;
            gen_hold[i]    = '0;
        end
        for (i = 0; i < NOTES; i++)
            holders[i] = '0;

        // directed: field extremes and the special cases
        add_event(ACT_ON, 0, 127);
        add_event(ACT_ON, 15, 1);
        add_event(ACT_ON, 5, 64);
        add_event(ACT_ON, 6, 63);
        add_event(ACT_ON, 0, 0);        // rest note
        add_event(ACT_ON, 0, 127);      // repeated note-on
        add_event(ACT_ON, 15, 127);     // second holder
        add_event(ACT_OFF, 0, 127);     // still voiced by the other track
        add_event(ACT_OFF, 0, 127);     // not held any more
        add_event(ACT_OFF, 3, 0);       // rest note
        add_event(ACT_OFF, 15, 127);
        add_event(ACT_ON, 10, 85);
        add_event(ACT_ON, 10, 42);
        add_event(ACT_RELEASE, 10, 127); // note field ignored
        add_event(ACT_RELEASE, 10, 0);   // nothing left to release
        add_event(ACT_CLEAR, 15, 127);   // store not empty
        add_event(ACT_CLEAR, 0, 0);      // store empty
        add_event(ACT_OFF, 9, 64);
        add_event(ACT_ON, 12, 127);
        add_event(ACT_ON, 3, 127);
        add_event(ACT_RELEASE, 3, 85);
        add_event(ACT_RELEASE, 0, 0);
        add_event(ACT_OFF, 12, 127);

        // random: mostly balanced on/off traffic, with chords, releases and clears
        for (i = 0; i < RANDOM_EVENTS; i++) begin
            r = $urandom_range(0, 99);
            trk = $urandom_range(0, TRACKS - 1);
            if (r < 2) begin
                note = pick_note();
                for (t = 0; t < TRACKS; t++)
                    add_event(ACT_ON, (trk + t) % TRACKS, note);
                i += TRACKS - 1;
            end else if (r < 4) begin
                add_event(ACT_CLEAR, trk, $urandom_range(0, NOTES - 1));
            end else if (r < 10) begin
                add_event(ACT_RELEASE, trk, $urandom_range(0, NOTES - 1));
            end else if (r < 55) begin
                add_event(ACT_ON, trk, pick_note());
            end else if (r < 90) begin
                note = pick_held(trk);
                if (note == 0 || $urandom_range(0, 4) == 0)
                    note = pick_note();
                add_event(ACT_OFF, trk, note);
            end else begin
                add_event(ACT_W'($urandom_range(0, 3)), trk, $urandom_range(0, NOTES - 1));
            end
        end

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_events.size() != 0 || s_tvalid || expected_voices.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        while (expected_voices.size() != 0) begin
            flag_error($sformatf("missing result voice=%0d changed=%0d",
                                 expected_voices[0].voice, expected_voices[0].changed));
            void'(expected_voices.pop_front());
        end

        if (err_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // sender: bursts of words with random gaps between them
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_taken) begin
            // word still waiting for acceptance
        end else if (gap_left != 0) begin
            s_tvalid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_events.size() != 0) begin
            s_tdata  <= IN_W'(pending_events.pop_front());
            s_tvalid <= 1'b1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 16);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: gap_left <= 0;
                    4, 5, 6, 7, 8: gap_left <= $urandom_range(1, 4);
                    default: gap_left <= $urandom_range(5, 24);
                endcase
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // receiver: stall pattern chosen by rx_cycle[8:7], plus one long hold-off
    int unsigned rx_cycle  = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && accepted_count >= HOLDOFF_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLDOFF_LEN;
            m_tready  <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            case (rx_cycle[8:7])
                2'd0: m_tready <= 1'b1;
                2'd1: m_tready <= 1'($urandom_range(0, 1));
                2'd2: m_tready <= (rx_cycle[1:0] == 2'd0);
                default: m_tready <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    // monitor: predict on each accepted event word, check each result word
    always @(posedge aclk) begin
        note_event_t   evt;
        voice_result_t want;
        voice_result_t got;
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                evt = s_tdata[$bits(note_event_t)-1:0];
                expected_voices.push_back(predict_voice(evt));
                accepted_count++;
            end
            if (m_tvalid && m_tready) begin
                got.voice   = m_tdata[NOTE_W-1:0];
                got.changed = m_tdata[NOTE_W];
                if (expected_voices.size() == 0) begin
                    flag_error($sformatf("unexpected result voice=%0d changed=%0d",
                                         got.voice, got.changed));
                end else begin
                    want = expected_voices.pop_front();
                    if (got.voice !== want.voice)
                        flag_error($sformatf("voiced_note expected %0d got %0d",
                                             want.voice, got.voice));
                    if (got.changed !== want.changed)
                        flag_error($sformatf("changed_hold expected %0d got %0d",
                                             want.changed, got.changed));
                end
            end
        end
    end

    // guard against a hung block
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/hnpt_pkg.sv
hdl/hnpt_ram.sv
hdl/hnpt_pick.sv
hdl/highest_note_priority_tracker.sv
hdl/hnpt_checker.sv
tb/testbench.sv
